@@ hdl/dwa_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package dwa_pkg;

	// Sizes of the lattice and of the node table
	localparam int MAX_NODES  = 1024;
	localparam int COORD_BITS = 11;
	localparam int ADDR_W     = $clog2(MAX_NODES);
	localparam int CNT_W      = $clog2(MAX_NODES + 1);
	localparam int PROD_W     = 2 * COORD_BITS;
	localparam int SQ_W       = 21;
	localparam int ROOT_W     = (SQ_W + 1) / 2;

	// Configuration
	localparam int CFG_W       = 11;
	localparam int CFG_IDX_W   = 1;
	localparam int LIMIT_W     = 11;
	localparam int MARGIN_W    = 10;
	localparam int LAUNCH_W    = 10;
	localparam int STEP_W      = 2;
	localparam int EVENT_W     = 3;

	localparam logic [CFG_IDX_W-1:0] REG_NODE_LIMIT    = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_LAUNCH_MARGIN = 1'b1;

	// Reset values and fixed constants
	localparam logic [LIMIT_W-1:0]  LIMIT_RST   = 11'd1024;
	localparam logic [MARGIN_W-1:0] MARGIN_RST  = 10'd10;
	localparam logic [SQ_W-1:0]     MAXSQ_RST   = 21'd5;
	localparam logic [ROOT_W-1:0]   TREE_RST    = 11'd2;
	localparam logic [CNT_W-1:0]    TOTAL_RST   = CNT_W'(2);
	localparam logic [LAUNCH_W-1:0] LAUNCH_MAX  = '1;
	localparam int                  ESCAPE_EXTRA = 10;
	localparam logic [COORD_BITS-1:0] SEED1_X   = COORD_BITS'(1);
	localparam logic [COORD_BITS-1:0] SEED1_Y   = COORD_BITS'(2);

	// Result event codes
	typedef enum logic [EVENT_W-1:0] {
		EV_MOVED    = 3'd0,
		EV_STUCK    = 3'd1,
		EV_ESCAPED  = 3'd2,
		EV_LANDED   = 3'd3,
		EV_STARTED  = 3'd4,
		EV_REJECTED = 3'd5
	} event_t;

	// Controller to datapath
	typedef struct packed {
		logic   load_item;
		logic   kill;
		logic   start_walker;
		logic   latch_move;
		logic   latch_square;
		logic   commit_pos;
		logic   scan_start;
		logic   scan_run;
		logic   append;
		logic   root_start;
		logic   root_take;
		logic   set_ev;
		event_t ev;
		logic   load_out;
	} dwa_cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic full;
		logic op;
		logic live;
		logic oor;
		logic escape;
		logic scan_done;
		logic on_tree;
		logic hit;
		logic root_done;
		logic out_free;
	} dwa_sts_t;

endpackage

`default_nettype wire

@@ hdl/dwa_isqrt.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Integer square root, one result bit per cycle (restoring digit method)
module dwa_isqrt (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           start,
	input  wire logic [dwa_pkg::SQ_W-1:0]       operand,
	output logic                                done,
	output logic [dwa_pkg::ROOT_W-1:0]          root
);

	localparam int RAD_W = 2 * dwa_pkg::ROOT_W;
	localparam int REM_W = dwa_pkg::ROOT_W + 2;
	localparam int CYC_W = $clog2(dwa_pkg::ROOT_W);

	logic [RAD_W-1:0]          rad_q;
	logic [REM_W-1:0]          rem_q;
	logic [dwa_pkg::ROOT_W-1:0] root_q;
	logic [CYC_W-1:0]          cyc_q;
	logic                      busy_q;
	logic                      done_q;

	logic [REM_W+1:0] rem_nx;
	logic [REM_W+1:0] trial;
	logic             take;

	// next partial remainder and trial divisor
	always_comb begin
		rem_nx = {rem_q, rad_q[RAD_W-1 -: 2]};
		trial  = (REM_W + 2)'({root_q, 2'b01});
		take   = (rem_nx >= trial);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cyc_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cyc_q  <= '0;
		end else if (busy_q) begin
			cyc_q <= cyc_q + 1'b1;
			if (cyc_q == CYC_W'(dwa_pkg::ROOT_W - 1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	// datapath registers, no reset needed
	always_ff @(posedge clk) begin
		if (start) begin
			rad_q  <= RAD_W'(operand);
			rem_q  <= '0;
			root_q <= '0;
		end else if (busy_q) begin
			rad_q <= {rad_q[RAD_W-3:0], 2'b00};
			if (take) begin
				rem_q  <= REM_W'(rem_nx - trial);
				root_q <= {root_q[dwa_pkg::ROOT_W-2:0], 1'b1};
			end else begin
				rem_q  <= rem_nx[REM_W-1:0];
				root_q <= {root_q[dwa_pkg::ROOT_W-2:0], 1'b0};
			end
		end
	end

	assign done = done_q;
	assign root = root_q;

endmodule

`default_nettype wire

@@ hdl/dwa_ctrl.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Sequencer for one word at a time
module dwa_ctrl (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              item_valid,
	output logic                   item_stall,
	input  wire dwa_pkg::dwa_sts_t sts,
	output dwa_pkg::dwa_cmd_t      cmd
);

	typedef enum logic [2:0] {
		IDLE,
		DECODE,
		MOVE,
		CHECK,
		SCAN,
		ROOT,
		FINISH
	} state_t;

	state_t state_q;
	state_t state_d;

	// command decode and next state
	always_comb begin
		cmd     = '0;
		state_d = state_q;
		unique case (state_q)
			IDLE: begin
				if (item_valid) begin
					cmd.load_item = 1'b1;
					state_d       = DECODE;
				end
			end
			DECODE: begin
				if (sts.full) begin
					cmd.kill   = 1'b1;
					cmd.set_ev = 1'b1;
					cmd.ev     = dwa_pkg::EV_REJECTED;
					state_d    = FINISH;
				end else if (!sts.op) begin
					cmd.start_walker = 1'b1;
					cmd.set_ev       = 1'b1;
					cmd.ev           = dwa_pkg::EV_STARTED;
					state_d          = FINISH;
				end else if (!sts.live) begin
					cmd.set_ev = 1'b1;
					cmd.ev     = dwa_pkg::EV_REJECTED;
					state_d    = FINISH;
				end else begin
					cmd.latch_move = 1'b1;
					state_d        = MOVE;
				end
			end
			MOVE: begin
				if (sts.oor) begin
					cmd.kill   = 1'b1;
					cmd.set_ev = 1'b1;
					cmd.ev     = dwa_pkg::EV_ESCAPED;
					state_d    = FINISH;
				end else begin
					cmd.latch_square = 1'b1;
					state_d          = CHECK;
				end
			end
			CHECK: begin
				cmd.commit_pos = 1'b1;
				if (sts.escape) begin
					cmd.kill   = 1'b1;
					cmd.set_ev = 1'b1;
					cmd.ev     = dwa_pkg::EV_ESCAPED;
					state_d    = FINISH;
				end else begin
					cmd.scan_start = 1'b1;
					state_d        = SCAN;
				end
			end
			SCAN: begin
				if (!sts.scan_done) begin
					cmd.scan_run = 1'b1;
				end else if (sts.on_tree) begin
					cmd.kill   = 1'b1;
					cmd.set_ev = 1'b1;
					cmd.ev     = dwa_pkg::EV_LANDED;
					state_d    = FINISH;
				end else if (sts.hit) begin
					cmd.append     = 1'b1;
					cmd.root_start = 1'b1;
					cmd.kill       = 1'b1;
					cmd.set_ev     = 1'b1;
					cmd.ev         = dwa_pkg::EV_STUCK;
					state_d        = ROOT;
				end else begin
					cmd.set_ev = 1'b1;
					cmd.ev     = dwa_pkg::EV_MOVED;
					state_d    = FINISH;
				end
			end
			ROOT: begin
				if (sts.root_done) begin
					cmd.root_take = 1'b1;
					state_d       = FINISH;
				end
			end
			FINISH: begin
				if (sts.out_free) begin
					cmd.load_out = 1'b1;
					state_d      = IDLE;
				end
			end
			default: state_d = IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign item_stall = (state_q != IDLE);

endmodule

`default_nettype wire

@@ hdl/dwa_dpath.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Walker, node table, radius tracking and result register
module dwa_dpath (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire logic                                 cfg_we,
	input  wire logic [dwa_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  wire logic [dwa_pkg::CFG_W-1:0]            cfg_data,
	input  wire logic                                 opcode,
	input  wire logic signed [dwa_pkg::COORD_BITS-1:0] start_x,
	input  wire logic signed [dwa_pkg::COORD_BITS-1:0] start_y,
	input  wire logic signed [dwa_pkg::STEP_W-1:0]    step_x,
	input  wire logic signed [dwa_pkg::STEP_W-1:0]    step_y,
	input  wire dwa_pkg::dwa_cmd_t                    cmd,
	output dwa_pkg::dwa_sts_t                         sts,
	input  wire logic                                 res_stall,
	output logic                                      res_valid,
	output logic [dwa_pkg::EVENT_W-1:0]               event_res,
	output logic signed [dwa_pkg::COORD_BITS-1:0]     pos_x,
	output logic signed [dwa_pkg::COORD_BITS-1:0]     pos_y,
	output logic [dwa_pkg::CNT_W-1:0]                 new_node,
	output logic [dwa_pkg::CNT_W-1:0]                 parent_node,
	output logic [dwa_pkg::LAUNCH_W-1:0]              launch_radius,
	output logic                                      tree_full
);

	localparam int CW  = dwa_pkg::COORD_BITS;
	localparam int PW  = dwa_pkg::PROD_W;
	localparam int NW  = dwa_pkg::CNT_W;
	localparam int AW  = dwa_pkg::ADDR_W;
	localparam int SW  = dwa_pkg::SQ_W;
	localparam int RW  = dwa_pkg::ROOT_W;
	localparam int LW  = dwa_pkg::LAUNCH_W;

	// configuration registers
	logic [dwa_pkg::LIMIT_W-1:0]  limit_q;
	logic [dwa_pkg::MARGIN_W-1:0] margin_q;

	// latched item
	logic                          op_q;
	logic [CW-1:0]                 sx_q;
	logic [CW-1:0]                 sy_q;
	logic [dwa_pkg::STEP_W-1:0]    dx_q;
	logic [dwa_pkg::STEP_W-1:0]    dy_q;

	// tree and walker state
	logic [NW-1:0]  total_q;
	logic [CW-1:0]  wx_q;
	logic [CW-1:0]  wy_q;
	logic           live_q;
	logic [SW-1:0]  maxsq_q;
	logic [RW-1:0]  tree_q;

	// move arithmetic
	logic [CW-1:0]  nx_q;
	logic [CW-1:0]  ny_q;
	logic           oor_q;
	logic [PW-1:0]  xsq_q;
	logic [PW-1:0]  ysq_q;
	logic [PW-1:0]  lrsq_q;
	logic [SW-1:0]  r2_q;

	// scan
	logic [NW-1:0]  idx_q;
	logic           rv_s1;
	logic           seed_s1;
	logic [NW-1:0]  idx_s1;
	logic [CW-1:0]  rdx_s1;
	logic [CW-1:0]  rdy_s1;
	logic           hit_q;
	logic           on_tree_q;
	logic [NW-1:0]  parent_q;

	dwa_pkg::event_t ev_q;
	logic            res_valid_q;

	// node table
	logic [CW-1:0] mem_x [dwa_pkg::MAX_NODES];
	logic [CW-1:0] mem_y [dwa_pkg::MAX_NODES];

	logic [NW-1:0]           lim_eff;
	logic                    full;
	logic [LW+1:0]           launch_sum;
	logic [LW-1:0]           launch_now;
	logic [RW-1:0]           lr;
	logic [dwa_pkg::STEP_W-1:0] dx_sat;
	logic [dwa_pkg::STEP_W-1:0] dy_sat;
	logic [CW:0]             nx;
	logic [CW:0]             ny;
	logic signed [PW-1:0]    xsq;
	logic signed [PW-1:0]    ysq;
	logic [PW:0]             sum;
	logic [SW-1:0]           r2_sat;
	logic [SW-1:0]           max_next;
	logic [CW-1:0]           ndx;
	logic [CW-1:0]           ndy;
	logic [CW:0]             ex;
	logic [CW:0]             ey;
	logic                    ex_near;
	logic                    ey_near;
	logic                    same;
	logic                    rd_en;
	logic                    root_done;
	logic [RW-1:0]           root;

	// limit, launch radius and escape circle
	always_comb begin
		lim_eff    = (NW'(limit_q) > NW'(dwa_pkg::MAX_NODES)) ?
			NW'(dwa_pkg::MAX_NODES) : NW'(limit_q);
		full       = (total_q >= lim_eff);
		launch_sum = (LW + 2)'(tree_q) + (LW + 2)'(margin_q);
		launch_now = (launch_sum > (LW + 2)'(dwa_pkg::LAUNCH_MAX)) ?
			dwa_pkg::LAUNCH_MAX : launch_sum[LW-1:0];
		lr         = RW'(launch_now) + RW'(dwa_pkg::ESCAPE_EXTRA);
	end

	// unit move, minus two counts as minus one
	always_comb begin
		dx_sat = (dx_q == 2'b10) ? 2'b11 : dx_q;
		dy_sat = (dy_q == 2'b10) ? 2'b11 : dy_q;
		nx     = {wx_q[CW-1], wx_q} + {{(CW - 1){dx_sat[1]}}, dx_sat};
		ny     = {wy_q[CW-1], wy_q} + {{(CW - 1){dy_sat[1]}}, dy_sat};
		xsq    = $signed(nx_q) * $signed(nx_q);
		ysq    = $signed(ny_q) * $signed(ny_q);
	end

	// squared radius of the moved walker, saturated
	always_comb begin
		sum      = (PW + 1)'(xsq_q) + (PW + 1)'(ysq_q);
		r2_sat   = (sum > (PW + 1)'({SW{1'b1}})) ? {SW{1'b1}} : sum[SW-1:0];
		max_next = (r2_q > maxsq_q) ? r2_q : maxsq_q;
	end

	// neighbor test against one table entry
	always_comb begin
		ndx     = seed_s1 ? dwa_pkg::SEED1_X : rdx_s1;
		ndy     = seed_s1 ? dwa_pkg::SEED1_Y : rdy_s1;
		ex      = {nx_q[CW-1], nx_q} - {ndx[CW-1], ndx};
		ey      = {ny_q[CW-1], ny_q} - {ndy[CW-1], ndy};
		ex_near = (ex == '0) || (ex == (CW + 1)'(1)) || (ex == '1);
		ey_near = (ey == '0) || (ey == (CW + 1)'(1)) || (ey == '1);
		same    = (ex == '0) && (ey == '0);
		rd_en   = cmd.scan_run && (idx_q < total_q);
	end

	dwa_isqrt u_isqrt (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (cmd.root_start),
		.operand (max_next),
		.done    (root_done),
		.root    (root)
	);

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q  <= dwa_pkg::LIMIT_RST;
			margin_q <= dwa_pkg::MARGIN_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				dwa_pkg::REG_NODE_LIMIT:    limit_q  <= cfg_data[dwa_pkg::LIMIT_W-1:0];
				dwa_pkg::REG_LAUNCH_MARGIN: margin_q <= cfg_data[dwa_pkg::MARGIN_W-1:0];
				default: ;
			endcase
		end
	end

	// tree and walker state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			total_q <= dwa_pkg::TOTAL_RST;
			wx_q    <= '0;
			wy_q    <= '0;
			live_q  <= 1'b0;
			maxsq_q <= dwa_pkg::MAXSQ_RST;
			tree_q  <= dwa_pkg::TREE_RST;
		end else begin
			if (cmd.start_walker) begin
				wx_q   <= sx_q;
				wy_q   <= sy_q;
				live_q <= 1'b1;
			end
			if (cmd.commit_pos) begin
				wx_q <= nx_q;
				wy_q <= ny_q;
			end
			if (cmd.kill) begin
				live_q <= 1'b0;
			end
			if (cmd.append) begin
				total_q <= total_q + 1'b1;
				maxsq_q <= max_next;
			end
			if (cmd.root_take) begin
				tree_q <= root;
			end
		end
	end

	// item latch and move arithmetic
	always_ff @(posedge clk) begin
		if (cmd.load_item) begin
			op_q <= opcode;
			sx_q <= start_x;
			sy_q <= start_y;
			dx_q <= step_x;
			dy_q <= step_y;
		end
		if (cmd.latch_move) begin
			nx_q  <= nx[CW-1:0];
			ny_q  <= ny[CW-1:0];
			oor_q <= (nx[CW] != nx[CW-1]) || (ny[CW] != ny[CW-1]);
		end
		if (cmd.latch_square) begin
			xsq_q  <= PW'(xsq);
			ysq_q  <= PW'(ysq);
			lrsq_q <= PW'(lr) * PW'(lr);
		end
		if (cmd.commit_pos) begin
			r2_q <= r2_sat;
		end
		if (cmd.set_ev) begin
			ev_q <= cmd.ev;
		end
	end

	// node table: one write, one registered read per cycle
	always_ff @(posedge clk) begin
		if (cmd.append) begin
			mem_x[total_q[AW-1:0]] <= nx_q;
			mem_y[total_q[AW-1:0]] <= ny_q;
		end
		if (rd_en) begin
			rdx_s1 <= mem_x[idx_q[AW-1:0]];
			rdy_s1 <= mem_y[idx_q[AW-1:0]];
		end
	end

	// table scan, first node is skipped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rv_s1 <= 1'b0;
		end else begin
			rv_s1 <= rd_en;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.scan_start) begin
			idx_q     <= NW'(1);
			hit_q     <= 1'b0;
			on_tree_q <= 1'b0;
			parent_q  <= '0;
		end else begin
			if (rd_en) begin
				idx_q   <= idx_q + 1'b1;
				idx_s1  <= idx_q;
				seed_s1 <= (idx_q == NW'(1));
			end
			if (rv_s1) begin
				if (same) begin
					on_tree_q <= 1'b1;
				end else if (ex_near && ey_near && !hit_q) begin
					hit_q    <= 1'b1;
					parent_q <= idx_s1 + 1'b1;
				end
			end
		end
	end

	// result word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (cmd.load_out) begin
			res_valid_q <= 1'b1;
		end else if (!res_stall) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			event_res     <= ev_q;
			pos_x         <= wx_q;
			pos_y         <= wy_q;
			new_node      <= (ev_q == dwa_pkg::EV_STUCK) ? total_q : '0;
			parent_node   <= (ev_q == dwa_pkg::EV_STUCK) ? parent_q : '0;
			launch_radius <= launch_now;
			tree_full     <= full;
		end
	end

	assign res_valid = res_valid_q;

	// status to the controller
	always_comb begin
		sts.full      = full;
		sts.op        = op_q;
		sts.live      = live_q;
		sts.oor       = oor_q;
		sts.escape    = (sum >= (PW + 1)'(lrsq_q));
		sts.scan_done = (idx_q >= total_q) && !rv_s1;
		sts.on_tree   = on_tree_q;
		sts.hit       = hit_q;
		sts.root_done = root_done;
		sts.out_free  = !res_valid_q || !res_stall;
	end

endmodule

`default_nettype wire

@@ hdl/dla_walker_aggregation.sv @@
// Start and rejected words go from DECODE to FINISH, out-of-range steps through MOVE; FINISH
// loads the result register. Other steps go through MOVE, CHECK and, unless they escape,
// SCAN; a sticking step adds ROOT for the bit-serial square root of the new maximum squared
// radius. A word is taken only once the last has left FINISH; the table scan reads one
// entry a cycle. The next word is taken while a result waits. Reset (arst_n low) restores
// the two seed nodes and the default registers at once; no clearing pass is needed.
`timescale 1ns / 1ps
`default_nettype none

module dla_walker_aggregation (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire logic                                 cfg_we,
	input  wire logic [dwa_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  wire logic [dwa_pkg::CFG_W-1:0]            cfg_data,
	input  wire logic                                 item_valid,
	output logic                                      item_stall,
	input  wire logic                                 opcode,
	input  wire logic signed [dwa_pkg::COORD_BITS-1:0] start_x,
	input  wire logic signed [dwa_pkg::COORD_BITS-1:0] start_y,
	input  wire logic signed [dwa_pkg::STEP_W-1:0]    step_x,
	input  wire logic signed [dwa_pkg::STEP_W-1:0]    step_y,
	output logic                                      res_valid,
	input  wire logic                                 res_stall,
	output logic [dwa_pkg::EVENT_W-1:0]               event_res,
	output logic signed [dwa_pkg::COORD_BITS-1:0]     pos_x,
	output logic signed [dwa_pkg::COORD_BITS-1:0]     pos_y,
	output logic [dwa_pkg::CNT_W-1:0]                 new_node,
	output logic [dwa_pkg::CNT_W-1:0]                 parent_node,
	output logic [dwa_pkg::LAUNCH_W-1:0]              launch_radius,
	output logic                                      tree_full
);

	dwa_pkg::dwa_cmd_t cmd;
	dwa_pkg::dwa_sts_t sts;

	dwa_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_stall (item_stall),
		.sts        (sts),
		.cmd        (cmd)
	);

	dwa_dpath u_dpath (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.opcode        (opcode),
		.start_x       (start_x),
		.start_y       (start_y),
		.step_x        (step_x),
		.step_y        (step_y),
		.cmd           (cmd),
		.sts           (sts),
		.res_stall     (res_stall),
		.res_valid     (res_valid),
		.event_res     (event_res),
		.pos_x         (pos_x),
		.pos_y         (pos_y),
		.new_node      (new_node),
		.parent_node   (parent_node),
		.launch_radius (launch_radius),
		.tree_full     (tree_full)
	);

endmodule

`default_nettype wire

@@ sim/dwa_walk_checker.sv @@
`timescale 1ns / 1ps

// Watches both channels and the register port, predicts every result word of
// the aggregation engine and compares it against what the block hands out.
module dwa_walk_checker
	import dwa_pkg::*;
(
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          cfg_we,
	input  wire logic [CFG_IDX_W-1:0]          cfg_index,
	input  wire logic [CFG_W-1:0]              cfg_data,
	input  wire logic                          item_valid,
	input  wire logic                          item_stall,
	input  wire logic                          opcode,
	input  wire logic signed [COORD_BITS-1:0]  start_x,
	input  wire logic signed [COORD_BITS-1:0]  start_y,
	input  wire logic signed [STEP_W-1:0]      step_x,
	input  wire logic signed [STEP_W-1:0]      step_y,
	input  wire logic                          res_valid,
	input  wire logic                          res_stall,
	input  wire logic [EVENT_W-1:0]            event_res,
	input  wire logic signed [COORD_BITS-1:0]  pos_x,
	input  wire logic signed [COORD_BITS-1:0]  pos_y,
	input  wire logic [CNT_W-1:0]              new_node,
	input  wire logic [CNT_W-1:0]              parent_node,
	input  wire logic [LAUNCH_W-1:0]           launch_radius,
	input  wire logic                          tree_full,
	output int                                 mismatches,
	output int                                 outstanding
);

	typedef logic signed [COORD_BITS-1:0] coord_t;

	typedef struct packed {
		event_t               ev;
		coord_t               px;
		coord_t               py;
		logic [CNT_W-1:0]     added;
		logic [CNT_W-1:0]     parent;
		logic [LAUNCH_W-1:0]  launch;
		logic                 full;
	} walk_word_t;

	localparam int CMIN   = -(1 << (COORD_BITS - 1));
	localparam int CMAX   = (1 << (COORD_BITS - 1)) - 1;
	localparam int SQ_SAT = (1 << SQ_W) - 1;

	// Shadow copy of the tree, the walker and the registers
	int tree_x [MAX_NODES];
	int tree_y [MAX_NODES];
	int node_count;
	int walk_x;
	int walk_y;
	bit walk_live;
	int peak_sq;
	int tree_rad;
	int limit_reg;
	int margin_reg;
	int errs;

	walk_word_t due_words [$];

	assign mismatches = errs;

	function automatic int sq_len(int x, int y);
		return x * x + y * y;
	endfunction

	function automatic int floor_root(int v);
		int r;
		r = 0;
		while ((r + 1) * (r + 1) <= v)
			r++;
		return r;
	endfunction

	function automatic int launch_now();
		int l;
		l = tree_rad + margin_reg;
		return (l > int'(LAUNCH_MAX)) ? int'(LAUNCH_MAX) : l;
	endfunction

	// limits above the table size are clamped to the table size
	function automatic bit grown_full();
		int lim;
		lim = (limit_reg < MAX_NODES) ? limit_reg : MAX_NODES;
		return node_count >= lim;
	endfunction

	// Advance the shadow state by one input word and return the result word
	function automatic walk_word_t predict_walk(logic op, coord_t sx, coord_t sy,
			logic signed [STEP_W-1:0] sdx, logic signed [STEP_W-1:0] sdy);
		walk_word_t w;
		int dx, dy, nx, ny, lr, d, r2, parent_idx;
		bit on_node, touched;
		w = '0;
		w.ev = EV_REJECTED;
		parent_idx = 0;
		if (grown_full()) begin
			walk_live = 1'b0;
		end else if (op == 1'b0) begin
			walk_x = sx;
			walk_y = sy;
			walk_live = 1'b1;
			w.ev = EV_STARTED;
		end else if (walk_live) begin
			// a step of -2 is taken as -1
			dx = sdx;
			dy = sdy;
			if (dx < -1) dx = -1;
			if (dy < -1) dy = -1;
			nx = walk_x + dx;
			ny = walk_y + dy;
			lr = launch_now() + ESCAPE_EXTRA;
			if (nx < CMIN || nx > CMAX || ny < CMIN || ny > CMAX) begin
				// off the lattice: escape, walker stays where it was
				walk_live = 1'b0;
				w.ev = EV_ESCAPED;
			end else if (sq_len(nx, ny) >= lr * lr) begin
				walk_x = nx;
				walk_y = ny;
				walk_live = 1'b0;
				w.ev = EV_ESCAPED;
			end else begin
				walk_x = nx;
				walk_y = ny;
				on_node = 1'b0;
				touched = 1'b0;
				// the first node never counts for landing or sticking
				for (int i = 1; i < node_count; i++) begin
					d = sq_len(nx - tree_x[i], ny - tree_y[i]);
					if (d == 0) begin
						on_node = 1'b1;
					end else if (d <= 2 && !touched) begin
						touched = 1'b1;
						parent_idx = i + 1;
					end
				end
				if (on_node) begin
					walk_live = 1'b0;
					w.ev = EV_LANDED;
				end else if (touched) begin
					r2 = sq_len(nx, ny);
					if (r2 > SQ_SAT) r2 = SQ_SAT;
					tree_x[node_count] = nx;
					tree_y[node_count] = ny;
					node_count++;
					w.added = CNT_W'(node_count);
					w.parent = CNT_W'(parent_idx);
					if (r2 > peak_sq) peak_sq = r2;
					tree_rad = floor_root(peak_sq);
					walk_live = 1'b0;
					w.ev = EV_STUCK;
				end else begin
					w.ev = EV_MOVED;
				end
			end
		end
		w.px = coord_t'(walk_x);
		w.py = coord_t'(walk_y);
		w.launch = LAUNCH_W'(launch_now());
		w.full = grown_full();
		return w;
	endfunction

	// Register writes, result compare, then prediction of the newly taken word
	always @(posedge clk or negedge arst_n) begin
		walk_word_t seen;
		walk_word_t want;
		if (!arst_n) begin
			tree_x[0] = 1;
			tree_y[0] = 1;
			tree_x[1] = SEED1_X;
			tree_y[1] = SEED1_Y;
			node_count = TOTAL_RST;
			walk_x = 0;
			walk_y = 0;
			walk_live = 1'b0;
			peak_sq = MAXSQ_RST;
			tree_rad = TREE_RST;
			limit_reg = LIMIT_RST;
			margin_reg = MARGIN_RST;
			errs = 0;
			due_words.delete();
			outstanding <= 0;
		end else begin
			if (cfg_we) begin
				if (cfg_index == REG_NODE_LIMIT)
					limit_reg = cfg_data[LIMIT_W-1:0];
				else if (cfg_index == REG_LAUNCH_MARGIN)
					margin_reg = cfg_data[MARGIN_W-1:0];
			end
			if (res_valid && !res_stall) begin
				seen.ev = event_t'(event_res);
				seen.px = pos_x;
				seen.py = pos_y;
				seen.added = new_node;
				seen.parent = parent_node;
				seen.launch = launch_radius;
				seen.full = tree_full;
				if (due_words.size() == 0) begin
					errs++;
					if (errs <= 10)
						$display("%0t: result word with none pending: ev %0d pos (%0d,%0d)",
							$realtime, event_res, pos_x, pos_y);
				end else begin
					want = due_words.pop_front();
					if (seen !== want) begin
						errs++;
						if (errs <= 10) begin
							$display("%0t: mismatch, want ev %0d pos (%0d,%0d) node %0d parent %0d launch %0d full %0d",
								$realtime, want.ev, want.px, want.py, want.added, want.parent,
								want.launch, want.full);
							$display("%0t:           got  ev %0d pos (%0d,%0d) node %0d parent %0d launch %0d full %0d",
								$realtime, event_res, pos_x, pos_y, new_node, parent_node,
								launch_radius, tree_full);
						end
					end
				end
			end
			if (item_valid && !item_stall)
				due_words.push_back(predict_walk(opcode, start_x, start_y, step_x, step_y));
			outstanding <= due_words.size();
		end
	end

endmodule

@@ sim/dla_walker_aggregation_test.sv @@
`timescale 1ns / 1ps

// Drives walker words and register settings into the aggregation engine and
// gives the verdict from the checker's counts.
module dla_walker_aggregation_test;
	import dwa_pkg::*;

	localparam int QUIET_LIMIT = 20000;
	localparam int PHASE_WORDS = 130;
	localparam int FILL_WORDS  = 40;

	logic                          clk = 1'b0;
	logic                          arst_n = 1'b0;
	logic                          cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0]          cfg_index = '0;
	logic [CFG_W-1:0]              cfg_data = '0;
	logic                          item_valid = 1'b0;
	logic                          item_stall;
	logic                          opcode = 1'b0;
	logic signed [COORD_BITS-1:0]  start_x = '0;
	logic signed [COORD_BITS-1:0]  start_y = '0;
	logic signed [STEP_W-1:0]      step_x = '0;
	logic signed [STEP_W-1:0]      step_y = '0;
	logic                          res_valid;
	logic                          res_stall = 1'b0;
	logic [EVENT_W-1:0]            event_res;
	logic signed [COORD_BITS-1:0]  pos_x;
	logic signed [COORD_BITS-1:0]  pos_y;
	logic [CNT_W-1:0]              new_node;
	logic [CNT_W-1:0]              parent_node;
	logic [LAUNCH_W-1:0]           launch_radius;
	logic                          tree_full;
	int                            mismatches;
	int                            outstanding;

	int words_sent = 0;
	int stuck_seen = 0;
	int tree_span = 2;
	int idle_cycles = 0;
	int stall_burst = 0;
	bit stall_quiet = 1'b0;
	bit send_quiet = 1'b0;

	dla_walker_aggregation dut (.*);

	dwa_walk_checker checker_i (.*);

	initial begin
		forever #4 clk = ~clk;
	end

	// Size of the grown tree, seen from stuck words, to aim new walkers
	always @(posedge clk) begin
		int ax, ay;
		ax = (pos_x < 0) ? -int'(pos_x) : int'(pos_x);
		ay = (pos_y < 0) ? -int'(pos_y) : int'(pos_y);
		if (res_valid && !res_stall && event_res == EV_STUCK) begin
			stuck_seen <= stuck_seen + 1;
			if (ax > tree_span || ay > tree_span)
				tree_span <= (ax > ay) ? ax : ay;
		end
	end

	// Result side backpressure: quiet stretches, short stalls, a few long bursts
	always @(posedge clk) begin
		int r;
		r = $urandom_range(0, 999);
		if (stall_burst > 0) begin
			res_stall <= 1'b1;
			stall_burst <= stall_burst - 1;
		end else if (r < 5) begin
			stall_quiet <= !stall_quiet;
			res_stall <= 1'b0;
		end else if (stall_quiet || r >= 300) begin
			res_stall <= 1'b0;
		end else if (r < 25) begin
			res_stall <= 1'b1;
			stall_burst <= $urandom_range(8, 60);
		end else begin
			res_stall <= 1'b1;
		end
	end

	// Watchdog on cycles without any handshake
	always @(posedge clk) begin
		if (!arst_n || (item_valid && !item_stall) || (res_valid && !res_stall)) begin
			idle_cycles <= 0;
		end else if (idle_cycles + 1 >= QUIET_LIMIT) begin
			$display("RESULT: ERROR");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	function automatic int pick_gap();
		int r;
		if (send_quiet)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(8, 50);
	endfunction

	function automatic int toward(int cur, int goal);
		return (cur < goal) ? 1 : ((cur > goal) ? -1 : 0);
	endfunction

	function automatic int rand_step();
		return int'($urandom_range(0, 3)) - 2;
	endfunction

	// One input word; returns at the edge that took it. Unused fields get noise.
	task automatic send_word(logic op, int sx, int sy, int dx, int dy);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			item_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		item_valid <= 1'b1;
		opcode <= op;
		start_x <= op ? COORD_BITS'($urandom) : COORD_BITS'(sx);
		start_y <= op ? COORD_BITS'($urandom) : COORD_BITS'(sy);
		step_x <= op ? STEP_W'(dx) : STEP_W'($urandom);
		step_y <= op ? STEP_W'(dy) : STEP_W'($urandom);
		do @(posedge clk); while (item_stall);
		words_sent++;
	endtask

	task automatic set_regs(int lim, int mrg);
		cfg_we <= 1'b1;
		cfg_index <= REG_NODE_LIMIT;
		cfg_data <= CFG_W'(lim);
		@(posedge clk);
		cfg_index <= REG_LAUNCH_MARGIN;
		cfg_data <= CFG_W'(mrg);
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	// Stop sending and wait for every pending result word
	task automatic settle();
		item_valid <= 1'b0;
		do @(posedge clk); while (outstanding != 0);
	endtask

	// Walker started near the tree, drifting toward the seeds with some noise
	task automatic drift_walk();
		int cx, cy, dx, dy, reach;
		reach = tree_span + 4;
		cx = int'($urandom_range(0, 2 * reach)) - reach;
		cy = int'($urandom_range(0, 2 * reach)) - reach;
		send_word(1'b0, cx, cy, 0, 0);
		repeat ($urandom_range(1, 30)) begin
			dx = ($urandom_range(0, 3) == 0) ? rand_step() : toward(cx, 1);
			dy = ($urandom_range(0, 3) == 0) ? rand_step() : toward(cy, 1);
			send_word(1'b1, 0, 0, dx, dy);
			cx += (dx < -1) ? -1 : dx;
			cy += (dy < -1) ? -1 : dy;
		end
	endtask

	// Start anywhere on the lattice, then a few random steps
	task automatic stray_walk();
		send_word(1'b0, $urandom, $urandom, 0, 0);
		repeat ($urandom_range(0, 3))
			send_word(1'b1, 0, 0, rand_step(), rand_step());
	endtask

	initial begin
		int lim, mrg, target, r;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// limit at the seed count: full from the start, all rejected
		set_regs(2, 1000);
		send_word(1'b0, 5, 5, 0, 0);
		send_word(1'b1, 0, 0, 1, 1);
		settle();

		// one node of room: step with no walker, restart, saturated step, stick
		set_regs(3, 0);
		send_word(1'b1, 0, 0, 1, 1);
		send_word(1'b0, 1, 4, 0, 0);
		send_word(1'b0, 1, 5, 0, 0);
		send_word(1'b1, 0, 0, 0, -2);
		send_word(1'b1, 0, 0, 0, -1);
		send_word(1'b1, 0, 0, 1, 0);
		send_word(1'b0, 0, 0, 0, 0);
		settle();

		// full table size: edge of the lattice, escape circle, landing, first node
		set_regs(MAX_NODES, 10);
		send_word(1'b0, -1024, -1024, 0, 0);
		send_word(1'b1, 0, 0, -1, -2);
		send_word(1'b0, 1023, 1023, 0, 0);
		send_word(1'b1, 0, 0, 1, 1);
		send_word(1'b0, 22, 0, 0, 0);
		send_word(1'b1, 0, 0, 1, 0);
		send_word(1'b0, 2, 3, 0, 0);
		send_word(1'b1, 0, 0, -1, 0);
		send_word(1'b0, 0, 0, 0, 0);
		send_word(1'b1, 0, 0, 1, 1);
		send_word(1'b1, 0, 0, 1, 1);
		send_word(1'b0, -3, -3, 0, 0);
		send_word(1'b1, 0, 0, 0, 0);
		send_word(1'b1, 0, 0, 1, 1);
		settle();

		// random growth under several margins, last phase runs into the limit
		for (int p = 0; p < 5; p++) begin
			case (p)
				1: mrg = 0;
				2: mrg = 1000;
				default: mrg = $urandom_range(1, 999);
			endcase
			lim = (p == 4) ? 2 + stuck_seen + int'($urandom_range(3, 8)) : MAX_NODES;
			set_regs(lim, mrg);
			target = words_sent + ((p == 4) ? FILL_WORDS : PHASE_WORDS);
			while (words_sent < target) begin
				if ($urandom_range(0, 19) == 0)
					send_quiet = !send_quiet;
				r = $urandom_range(0, 99);
				if (r < 80)
					drift_walk();
				else if (r < 92)
					stray_walk();
				else
					send_word(1'b1, 0, 0, rand_step(), rand_step());
			end
			settle();
		end

		repeat (64) @(posedge clk);
		if (mismatches == 0 && outstanding == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end

endmodule
